// ===== rtl/aq_pkg.sv =====
// ----------------------------------------------------------------------------
// aq_pkg: shared types and codes for the ascending priority queue
// Command codes, item payload structs, controller state and control struct.
// ----------------------------------------------------------------------------
package aq_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] removed_value;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

  typedef enum logic {
    ST_ACCEPT,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic apply;
  } ctrl_t;

endpackage

// ===== rtl/aq_req_if.sv =====
// ----------------------------------------------------------------------------
// aq_req_if: request channel
// Valid/ready channel carrying one queue command item.
// ----------------------------------------------------------------------------
interface aq_req_if import aq_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/aq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// aq_rsp_if: response channel
// Valid/ready channel carrying one queue result item.
// ----------------------------------------------------------------------------
interface aq_rsp_if import aq_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/aq_ctrl.sv =====
// ----------------------------------------------------------------------------
// aq_ctrl: queue controller
// Two-state sequencer: latch an item, then apply it to the cell chain and
// load the result register. Tracks the result register's valid flag.
// ----------------------------------------------------------------------------
module aq_ctrl import aq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  output logic  rsp_valid,
  input  logic  rsp_ready,
  output ctrl_t ctrl
);

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCEPT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // take a new item only when the result register is free or drains now
  assign req_ready = (state == ST_ACCEPT) && (!out_valid || rsp_ready);
  assign rsp_valid = out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_ACCEPT: begin
        if (req_valid && req_ready) state_next = ST_APPLY;
      end
      ST_APPLY: state_next = ST_ACCEPT;
      default:  state_next = ST_ACCEPT;
    endcase
  end

  always_comb begin
    ctrl.load  = 1'b0;
    ctrl.apply = 1'b0;
    unique case (state)
      ST_ACCEPT: ctrl.load  = req_valid && req_ready;
      ST_APPLY:  ctrl.apply = 1'b1;
      default: begin
        ctrl.load  = 1'b0;
        ctrl.apply = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (ctrl.apply) begin
      out_valid_next = 1'b1;
    end else if (out_valid && rsp_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

// ===== rtl/aq_dp.sv =====
// ----------------------------------------------------------------------------
// aq_dp: queue datapath
// Chain of compare-and-shift cells holding the sorted values, the fill
// count, the latched item and the result register.
// ----------------------------------------------------------------------------
module aq_dp import aq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  ctrl_t ctrl,
  input  req_t  req_data,
  output rsp_t  rsp_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic signed [31:0] cells [DEPTH];
  logic signed [31:0] cells_next [DEPTH];
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  req_t               item;
  rsp_t               result;
  rsp_t               result_next;

  logic [DEPTH-1:0]   gt;
  logic               do_insert;
  logic               do_remove;

  assign do_insert = (item.command == CMD_INSERT) && (count != FULL_COUNT);
  assign do_remove = (item.command == CMD_REMOVE) && (count != '0);

  // cell i holds a value greater than the new one; ones form a run up to count
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic shift_in;
    logic place;

    assign gt[i] = (CW'(i) < count) && (cells[i] > item.value);

    if (i == 0) begin : g_head
      assign shift_in = 1'b0;
    end else begin : g_body
      assign shift_in = gt[i-1];
    end
    assign place = (gt[i] || (CW'(i) == count)) && !shift_in;

    always_comb begin
      cells_next[i] = cells[i];
      if (do_insert) begin
        if (shift_in) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end else if (place) begin
          cells_next[i] = item.value;
        end
      end else if (do_remove) begin
        if (i < DEPTH - 1) begin
          cells_next[i] = cells[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CW'(1);
    end else if (do_remove) begin
      count_next = count - CW'(1);
    end
    result_next.ok            = do_insert || do_remove;
    result_next.removed_value = do_remove ? cells[0] : 32'sd0;
    result_next.is_empty      = (count_next == '0);
    result_next.is_full       = (count_next == FULL_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.apply) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item <= req_data;
    end
    if (ctrl.apply) begin
      result <= result_next;
      for (int k = 0; k < DEPTH; k++) begin
        cells[k] <= cells_next[k];
      end
    end
  end

  assign rsp_data = result;

endmodule

// ===== rtl/ascending_priority_queue.sv =====
// ----------------------------------------------------------------------------
// ascending_priority_queue: bounded sorted queue of signed 32-bit values
// Insert places a value after all equal ones; remove returns the smallest.
//
//   Channel  Dir  Payload                                    Accept
//   req      in   command, value                             valid && ready
//   rsp      out  ok, removed_value, is_empty, is_full        valid && ready
//
// Each item is first latched; then the cell chain compares and shifts all
// entries in parallel and loads the result register.
// Reset clears the fill count and the controller; cells need no clearing.
// A result waits in its register until rsp takes it; req ready stays low
// while it waits, except in the cycle that rsp takes it.
// ----------------------------------------------------------------------------
module ascending_priority_queue import aq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  aq_req_if.sink   req,
  aq_rsp_if.source rsp
);

  ctrl_t ctrl;

  aq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  aq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .req_data (req.data),
    .rsp_data (rsp.data)
  );

endmodule
